FILE: rtl/mhe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mhe_pkg;
   localparam int Capacity  = 1024;
   localparam int DataWidth = 32;
   localparam int AddrWidth = $clog2(Capacity);
   localparam int CountWidth = AddrWidth + 1;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_BUILD  = 2'd1;
   localparam logic [1:0] CMD_SORT   = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_RANGE = 2'd1;
   localparam logic [1:0] ERR_FULL  = 2'd2;

   typedef logic [DataWidth-1:0] data_type;
   typedef logic [AddrWidth-1:0] addr_type;
   typedef logic [CountWidth-1:0] count_type;
endpackage
`default_nettype wire

FILE: rtl/max_heap_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Binary max heap engine with heapsort, backed by one synchronous memory.
// Input channel (req_*): command, value and index; an item is taken when
// req_valid is high and req_stall is low. Result channel (rsp_*): one item
// per command with read_value, count and error_code, held in an output
// register while rsp_stall is high. The engine works one item at a time;
// req_stall is high while a command is in progress. All memory traffic goes
// through one port pair, one write and one registered read per cycle, so the
// memory port sets how long each command takes: read waits on one memory read;
// insert climbs up to one level per parent compare (at most 10 levels);
// build sifts each parent down; sort builds, then swaps the root with the last
// unsorted slot and sifts the root down for each extraction.
// A result is valid the cycle after the command's last step.
// Reset empties the store (count zero); memory contents are
// left undefined and never observed. While a result waits in the output
// register the engine takes the next item, and holds it in its final step
// until the register is free.
module max_heap_engine
   import mhe_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_command,
   input  wire logic [31:0]            req_value,
   input  wire logic [9:0]             req_index,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [31:0]                 rsp_read_value,
   output logic [10:0]                 rsp_count,
   output logic [1:0]                  rsp_error_code
);
   // State codes.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RDWAIT = 4'd1;
   localparam logic [3:0] S_UPRD   = 4'd2;
   localparam logic [3:0] S_UPCMP  = 4'd3;
   localparam logic [3:0] S_DNRD   = 4'd4;
   localparam logic [3:0] S_DNL    = 4'd5;
   localparam logic [3:0] S_DNR    = 4'd6;
   localparam logic [3:0] S_DNCMP  = 4'd7;
   localparam logic [3:0] S_DNWR   = 4'd8;
   localparam logic [3:0] S_NEXT   = 4'd9;
   localparam logic [3:0] S_SWRD   = 4'd10;
   localparam logic [3:0] S_SWA    = 4'd11;
   localparam logic [3:0] S_SWB    = 4'd12;
   localparam logic [3:0] S_RESP   = 4'd13;
   localparam logic [3:0] S_UPWR   = 4'd14;

   data_type mem [Capacity];
   data_type rdata_ff;
   logic     wen;
   addr_type waddr, raddr;
   data_type wdata;

   logic [3:0] state_ff, state_in;
   count_type  count_ff, count_in;
   count_type  pos_ff, pos_in;     // current node
   count_type  cand_ff, cand_in;   // parent or larger child
   count_type  lim_ff, lim_in;     // heap bound for sift-down
   count_type  iter_ff, iter_in;   // build parent counter
   data_type   cur_ff, cur_in;     // value being moved
   data_type   big_ff, big_in;     // best child value
   data_type   rv_ff, rv_in;
   logic [1:0] err_ff, err_in;
   logic       sorting_ff, sorting_in;

   // Output register for the result item.
   logic       out_load;
   logic       out_valid_ff, out_valid_in;
   data_type   out_value_ff, out_value_in;
   count_type  out_count_ff, out_count_in;
   logic [1:0] out_err_ff, out_err_in;

   // Memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = out_valid_ff;
   assign rsp_read_value = out_value_ff;
   assign rsp_count      = out_count_ff;
   assign rsp_error_code = out_err_ff;

   // Child indices of the current node.
   count_type lchild, rchild;
   assign lchild = count_type'({pos_ff[CountWidth-2:0], 1'b1});
   assign rchild = lchild + count_type'(1);

   // The output register takes a new result when it is empty or being emptied.
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_value_in = out_value_ff;
      out_count_in = out_count_ff;
      out_err_in   = out_err_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_value_in = rv_ff;
         out_count_in = count_ff;
         out_err_in   = err_ff;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      cand_in    = cand_ff;
      lim_in     = lim_ff;
      iter_in    = iter_ff;
      cur_in     = cur_ff;
      big_in     = big_ff;
      rv_in      = rv_ff;
      err_in     = err_ff;
      sorting_in = sorting_ff;
      out_load   = 1'b0;
      wen   = 1'b0;
      waddr = pos_ff[AddrWidth-1:0];
      wdata = cur_ff;
      raddr = cand_ff[AddrWidth-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rv_in  = '0;
               err_in = ERR_OK;
               case (req_command)
                  CMD_INSERT: begin
                     if (count_ff >= count_type'(Capacity)) begin
                        err_in   = ERR_FULL;
                        state_in = S_RESP;
                     end else begin
                        cur_in   = data_type'(req_value);
                        pos_in   = count_ff;
                        count_in = count_ff + count_type'(1);
                        state_in = S_UPRD;
                     end
                  end
                  CMD_READ: begin
                     if (count_type'(req_index) < count_ff) begin
                        raddr    = addr_type'(req_index);
                        state_in = S_RDWAIT;
                     end else begin
                        err_in   = ERR_RANGE;
                        state_in = S_RESP;
                     end
                  end
                  default: begin
                     // Build or sort: start with the last parent.
                     sorting_in = (req_command == CMD_SORT);
                     lim_in     = count_ff;
                     iter_in    = count_ff >> 1;
                     state_in   = S_NEXT;
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            rv_in    = rdata_ff;
            state_in = S_RESP;
         end
         // Sift up: hole at pos holds cur conceptually; compare with parent.
         S_UPRD: begin
            if (pos_ff == '0) begin
               state_in = S_UPWR;
            end else begin
               cand_in  = (pos_ff - count_type'(1)) >> 1;
               raddr    = addr_type'((pos_ff - count_type'(1)) >> 1);
               state_in = S_UPCMP;
            end
         end
         S_UPCMP: begin
            if (cur_ff > rdata_ff) begin
               wen      = 1'b1;
               wdata    = rdata_ff;
               pos_in   = cand_ff;
               state_in = S_UPRD;
            end else begin
               state_in = S_UPWR;
            end
         end
         S_UPWR: begin
            wen      = 1'b1;
            state_in = S_RESP;
         end
         // Pick the next parent to sift, or the next sort extraction.
         S_NEXT: begin
            if (iter_ff != '0) begin
               iter_in  = iter_ff - count_type'(1);
               pos_in   = iter_ff - count_type'(1);
               cand_in  = iter_ff - count_type'(1);
               raddr    = addr_type'(iter_ff - count_type'(1));
               state_in = S_DNRD;
            end else if (sorting_ff && lim_ff > count_type'(1)) begin
               lim_in   = lim_ff - count_type'(1);
               raddr    = '0;
               state_in = S_SWRD;
            end else begin
               state_in = S_RESP;
            end
         end
         // Swap root with last unsorted slot, then sift root down.
         S_SWRD: begin
            big_in   = rdata_ff;                 // root
            raddr    = lim_ff[AddrWidth-1:0];
            state_in = S_SWA;
         end
         S_SWA: begin
            cur_in   = rdata_ff;                 // last unsorted element
            wen      = 1'b1;
            waddr    = lim_ff[AddrWidth-1:0];
            wdata    = big_ff;
            pos_in   = '0;
            state_in = S_SWB;
         end
         S_SWB: begin
            raddr    = lchild[AddrWidth-1:0];
            state_in = (lchild < lim_ff) ? S_DNL : S_DNWR;
         end
         // Sift down: hold the moving value in cur, hole at pos.
         S_DNRD: begin
            cur_in   = rdata_ff;
            raddr    = lchild[AddrWidth-1:0];
            state_in = (lchild < lim_ff) ? S_DNL : S_DNWR;
         end
         S_DNL: begin
            big_in   = rdata_ff;
            cand_in  = lchild;
            raddr    = rchild[AddrWidth-1:0];
            state_in = (rchild < lim_ff) ? S_DNR : S_DNCMP;
         end
         S_DNR: begin
            if (rdata_ff > big_ff) begin
               big_in  = rdata_ff;
               cand_in = rchild;
            end
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            if (big_ff > cur_ff) begin
               wen      = 1'b1;
               wdata    = big_ff;
               pos_in   = cand_ff;
               state_in = S_SWB;
            end else begin
               state_in = S_DNWR;
            end
         end
         S_DNWR: begin
            wen      = 1'b1;
            state_in = S_NEXT;
         end
         // Hand the result to the output register once it is free.
         S_RESP: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sorting_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sorting_ff   <= sorting_in;
         out_valid_ff <= out_valid_in;
      end
      pos_ff       <= pos_in;
      cand_ff      <= cand_in;
      lim_ff       <= lim_in;
      iter_ff      <= iter_in;
      cur_ff       <= cur_in;
      big_ff       <= big_in;
      rv_ff        <= rv_in;
      err_ff       <= err_in;
      out_value_ff <= out_value_in;
      out_count_ff <= out_count_in;
      out_err_ff   <= out_err_in;
   end
endmodule
`default_nettype wire
